@@ rtl/core/gvq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package gvq_pkg;

  localparam int DEF_NUM_POINTS = 42;
  localparam int PNT_W          = 6;
  localparam int VEC_W          = 16;
  localparam int SPREAD_W       = 17;
  localparam int WEIGHT_W       = 32;
  localparam int LEN_W          = 32;
  localparam int DOT_W          = 34;
  localparam int ROOT_STEPS     = 32;
  localparam int DP_W           = 48;
  localparam int T_W            = 32;
  localparam int N_W            = 50;

  localparam logic [SPREAD_W-1:0] SPREAD_ONE = 17'h10000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 32'hFFFF_FFFF;

  localparam logic ACT_LOAD     = 1'b0;
  localparam logic ACT_QUANTIZE = 1'b1;

  // sideband that travels with each table point down the pipeline
  typedef struct packed {
    logic [PNT_W-1:0] idx;
    logic             last;
    logic             scan;
    logic             near;
    logic             hit;
    logic             kill;
    logic             sat;
  } gvq_side_t;

endpackage
`default_nettype wire

@@ rtl/core/gvq_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface gvq_in_if;
  import gvq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic signed [VEC_W-1:0] vec_x;
  logic signed [VEC_W-1:0] vec_y;
  logic signed [VEC_W-1:0] vec_z;
  logic [PNT_W-1:0]        point_index;
  modport source (output valid, action, vec_x, vec_y, vec_z, point_index, input ready);
  modport sink (input valid, action, vec_x, vec_y, vec_z, point_index, output ready);
endinterface

interface gvq_out_if;
  import gvq_pkg::*;
  logic                valid;
  logic                ready;
  logic [PNT_W-1:0]    bin_index;
  logic [WEIGHT_W-1:0] weight;
  logic                last;
  modport source (output valid, bin_index, weight, last, input ready);
  modport sink (input valid, bin_index, weight, last, output ready);
endinterface

interface gvq_cfg_if;
  import gvq_pkg::*;
  logic                valid;
  logic                ready;
  logic [SPREAD_W-1:0] spread;
  modport source (output valid, spread, input ready);
  modport sink (input valid, spread, output ready);
endinterface
`default_nettype wire

@@ rtl/core/geodesic_vector_quantizer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake      payload
// in_ch     in   valid/ready    action, vec_x, vec_y, vec_z, point_index
// out_ch    out  valid/ready    bin_index, weight, last
// cfg_ch    in   valid/ready    spread
//
// a load writes its table point without leaving idle; a quantize holds off the input until
// its last beat is taken, and nearest mode with a nonzero vector adds a table scan first
// the square-root unit takes 32 steps and the 80 divider cells (48 for the dot/length
// quotient, 32 for the spread quotient) take one point per cycle unless stalled
// synchronous active-low reset clears control state; the table holds no reset value
// out_ch back-pressure stalls every stage and the divider cells together
module geodesic_vector_quantizer #(
  parameter int NUM_POINTS = gvq_pkg::DEF_NUM_POINTS
) (
  input wire logic clk,
  input wire logic rst_n,
  gvq_in_if.sink   in_ch,
  gvq_out_if.source out_ch,
  gvq_cfg_if.sink  cfg_ch
);
  import gvq_pkg::*;

  localparam int AW = $clog2(NUM_POINTS);
  localparam logic [PNT_W-1:0] LAST_IDX = PNT_W'(NUM_POINTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQUARE, ST_ROOT_GO, ST_ROOT, ST_SCAN, ST_SCAN_WAIT, ST_EMIT, ST_DRAIN
  } state_t;

  state_t                  state_r;
  logic [SPREAD_W-1:0]     spread_r;
  logic [SPREAD_W-1:0]     s_eff;
  logic signed [VEC_W-1:0] x_r, y_r, z_r;
  logic [31:0]             sqx_r, sqy_r, sqz_r;
  logic [31:0]             sum_sq;
  logic [LEN_W-1:0]        len_r;
  logic                    zero_r;
  logic                    near_r;
  logic [PNT_W-1:0]        cnt_r;
  logic [PNT_W-1:0]        best_r;
  logic signed [DOT_W-1:0] best_dot_r;
  logic                    adv;
  logic                    issuing;
  logic                    scan_done;
  logic                    root_done;
  logic [LEN_W-1:0]        root;
  logic                    ram_we;
  logic [3*VEC_W-1:0]      ram_rdata;

  // pipeline registers
  logic                    a_v_r, b_v_r, c_v_r, e_v_r, f_v_r, g_v_r;
  gvq_side_t               a_side_r, b_side_r, c_side_r, e_side_r, f_side_r, g_side_r;
  gvq_side_t               a_side_nxt, c_side_nxt, e_side_nxt;
  logic signed [31:0]      px_r, py_r, pz_r;
  logic signed [DOT_W-1:0] dot_b;
  logic signed [DOT_W-1:0] c_dot_r;
  logic [SPREAD_W-1:0]     e_rem_r;
  logic [T_W-1:0]          e_dq_r;
  logic [63:0]             f_tt_r;
  logic [63:0]             g_hp_r, g_lp_r;
  logic                    d1_v, d2_v;
  logic [DP_W-1:0]         d1_q;
  logic [T_W-1:0]          d2_q;
  gvq_side_t               d1_side, d2_side;
  logic signed [N_W-1:0]   n_val;
  logic [64:0]             w_sum;
  logic [WEIGHT_W-1:0]     w_nxt;

  logic                    out_v_r;
  logic [PNT_W-1:0]        out_bin_r;
  logic [WEIGHT_W-1:0]     out_w_r;
  logic                    out_last_r;

  assign adv     = !out_v_r || out_ch.ready;
  assign issuing = (state_r == ST_SCAN || state_r == ST_EMIT) && adv;
  assign s_eff   = (spread_r > SPREAD_ONE) ? SPREAD_ONE : spread_r;
  assign sum_sq  = sqx_r + sqy_r + sqz_r;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spread_r <= '0;
    end else if (cfg_ch.valid) begin
      spread_r <= cfg_ch.spread;
    end
  end

  assign ram_we = in_ch.valid && (state_r == ST_IDLE) && (in_ch.action == ACT_LOAD) &&
                  ({1'b0, in_ch.point_index} < (PNT_W + 1)'(NUM_POINTS));

  gvq_ram #(.WIDTH(3 * VEC_W), .DEPTH(NUM_POINTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_ch.point_index[AW-1:0]),
    .wdata ({in_ch.vec_x, in_ch.vec_y, in_ch.vec_z}),
    .re    (issuing),
    .raddr (cnt_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  gvq_isqrt u_root (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == ST_ROOT_GO),
    .sum_sq (sum_sq),
    .done   (root_done),
    .root   (root)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid && in_ch.action == ACT_QUANTIZE) begin
            x_r     <= in_ch.vec_x;
            y_r     <= in_ch.vec_y;
            z_r     <= in_ch.vec_z;
            near_r  <= (spread_r == '0);
            state_r <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          sqx_r   <= 32'(x_r * x_r);
          sqy_r   <= 32'(y_r * y_r);
          sqz_r   <= 32'(z_r * z_r);
          state_r <= ST_ROOT_GO;
        end
        ST_ROOT_GO: begin
          zero_r  <= (sum_sq == '0);
          state_r <= ST_ROOT;
        end
        ST_ROOT: begin
          if (root_done) begin
            len_r   <= root;
            cnt_r   <= '0;
            state_r <= (near_r && !zero_r) ? ST_SCAN : ST_EMIT;
          end
        end
        ST_SCAN: begin
          if (adv) begin
            cnt_r <= (cnt_r == LAST_IDX) ? '0 : cnt_r + 1'b1;
            if (cnt_r == LAST_IDX) begin
              state_r <= ST_SCAN_WAIT;
            end
          end
        end
        ST_SCAN_WAIT: begin
          if (scan_done) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (adv) begin
            cnt_r <= (cnt_r == LAST_IDX) ? '0 : cnt_r + 1'b1;
            if (cnt_r == LAST_IDX) begin
              state_r <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (out_v_r && out_ch.ready && out_last_r) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    a_side_nxt      = '0;
    a_side_nxt.idx  = cnt_r;
    a_side_nxt.last = (cnt_r == LAST_IDX);
    a_side_nxt.scan = (state_r == ST_SCAN);
    a_side_nxt.near = near_r;
    a_side_nxt.hit  = (cnt_r == best_r);
    a_side_nxt.kill = zero_r;
  end

  assign dot_b = DOT_W'(px_r) + DOT_W'(py_r) + DOT_W'(pz_r);

  always_comb begin
    c_side_nxt = b_side_r;
    if (!b_side_r.near && (dot_b[DOT_W-1] || dot_b == '0)) begin
      c_side_nxt.kill = 1'b1;
    end
  end

  assign scan_done = adv && b_v_r && b_side_r.scan && b_side_r.last;

  // front: table read, products, dot sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= issuing;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r && !b_side_r.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_side_r <= a_side_nxt;
      b_side_r <= a_side_r;
      px_r     <= x_r * $signed(ram_rdata[3*VEC_W-1 -: VEC_W]);
      py_r     <= y_r * $signed(ram_rdata[2*VEC_W-1 -: VEC_W]);
      pz_r     <= z_r * $signed(ram_rdata[VEC_W-1:0]);
      c_side_r <= c_side_nxt;
      c_dot_r  <= dot_b;
      // running argmax, lowest index wins ties
      if (b_v_r && b_side_r.scan && (b_side_r.idx == '0 || dot_b > best_dot_r)) begin
        best_r     <= b_side_r.idx;
        best_dot_r <= dot_b;
      end
    end
  end

  gvq_div_chain #(.DW(LEN_W), .QW(DP_W)) u_div_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .divisor  (len_r),
    .in_v     (c_v_r),
    .in_rem   ('0),
    .in_dq    ({c_dot_r[31:0], 16'h0}),
    .in_side  (c_side_r),
    .out_v    (d1_v),
    .out_q    (d1_q),
    .out_side (d1_side)
  );

  assign n_val = $signed({2'b00, d1_q}) - $signed(N_W'(SPREAD_ONE)) + $signed(N_W'(s_eff));

  always_comb begin
    e_side_nxt = d1_side;
    if (!d1_side.near) begin
      if (n_val[N_W-1] || n_val == '0) begin
        e_side_nxt.kill = 1'b1;
      end
      if (n_val >= $signed(N_W'({s_eff, 16'h0}))) begin
        e_side_nxt.sat = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
      g_v_r <= 1'b0;
    end else if (adv) begin
      e_v_r <= d1_v;
      f_v_r <= d2_v;
      g_v_r <= f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_side_r <= e_side_nxt;
      e_rem_r  <= {1'b0, n_val[31:16]};
      e_dq_r   <= {n_val[15:0], 16'h0};
      f_side_r <= d2_side;
      f_tt_r   <= d2_q * d2_q;
      g_side_r <= f_side_r;
      g_hp_r   <= f_tt_r[63:32] * len_r;
      g_lp_r   <= f_tt_r[31:0] * len_r;
    end
  end

  gvq_div_chain #(.DW(SPREAD_W), .QW(T_W)) u_div_t (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .divisor  (s_eff),
    .in_v     (e_v_r),
    .in_rem   (e_rem_r),
    .in_dq    (e_dq_r),
    .in_side  (e_side_r),
    .out_v    (d2_v),
    .out_q    (d2_q),
    .out_side (d2_side)
  );

  assign w_sum = {1'b0, g_hp_r} + {33'b0, g_lp_r[63:32]};

  always_comb begin
    if (g_side_r.kill) begin
      w_nxt = '0;
    end else if (g_side_r.near) begin
      w_nxt = g_side_r.hit ? len_r : '0;
    end else if (g_side_r.sat || w_sum[64:32] != '0) begin
      w_nxt = WEIGHT_MAX;
    end else begin
      w_nxt = w_sum[31:0];
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= g_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_bin_r  <= g_side_r.idx;
      out_w_r    <= w_nxt;
      out_last_r <= g_side_r.last;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.bin_index = out_bin_r;
  assign out_ch.weight    = out_w_r;
  assign out_ch.last      = out_last_r;

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_last_r |-> out_bin_r == LAST_IDX)
    else $error("last beat not on final point");

  a_root_state: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> state_r == ST_ROOT)
    else $error("root done outside root wait");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !out_v_r && !a_v_r && !g_v_r)
    else $error("beat in flight while idle");

  a_no_scan_div: assert property (@(posedge clk) disable iff (!rst_n)
    c_v_r |-> !c_side_r.scan)
    else $error("scan point entered divider");

endmodule
`default_nettype wire

@@ rtl/core/gvq_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gvq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 42
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/gvq_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gvq_div_cell #(
  parameter int DW = 32,
  parameter int QW = 48
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic [DW-1:0]       divisor,
  input  wire logic                in_v,
  input  wire logic [DW-1:0]       in_rem,
  input  wire logic [QW-1:0]       in_dq,
  input  wire gvq_pkg::gvq_side_t  in_side,
  output      logic                out_v,
  output      logic [DW-1:0]       out_rem,
  output      logic [QW-1:0]       out_dq,
  output      gvq_pkg::gvq_side_t  out_side
);
  import gvq_pkg::*;

  logic [DW:0] sh;
  logic [DW:0] diff;
  logic        ge;

  // one restoring step: next dividend bit in, quotient bit out
  always_comb begin
    sh   = {in_rem, in_dq[QW-1]};
    diff = sh - {1'b0, divisor};
    ge   = sh >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= ge ? diff[DW-1:0] : sh[DW-1:0];
      out_dq   <= {in_dq[QW-2:0], ge};
      out_side <= in_side;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/gvq_div_chain.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gvq_div_chain #(
  parameter int DW = 32,
  parameter int QW = 48
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic [DW-1:0]       divisor,
  input  wire logic                in_v,
  input  wire logic [DW-1:0]       in_rem,
  input  wire logic [QW-1:0]       in_dq,
  input  wire gvq_pkg::gvq_side_t  in_side,
  output      logic                out_v,
  output      logic [QW-1:0]       out_q,
  output      gvq_pkg::gvq_side_t  out_side
);
  import gvq_pkg::*;

  logic              v    [QW+1];
  logic [DW-1:0]     rem  [QW+1];
  logic [QW-1:0]     dq   [QW+1];
  gvq_side_t         side [QW+1];

  assign v[0]    = in_v;
  assign rem[0]  = in_rem;
  assign dq[0]   = in_dq;
  assign side[0] = in_side;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    gvq_div_cell #(.DW(DW), .QW(QW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .divisor  (divisor),
      .in_v     (v[i]),
      .in_rem   (rem[i]),
      .in_dq    (dq[i]),
      .in_side  (side[i]),
      .out_v    (v[i+1]),
      .out_rem  (rem[i+1]),
      .out_dq   (dq[i+1]),
      .out_side (side[i+1])
    );
  end

  assign out_v    = v[QW];
  assign out_q    = dq[QW];
  assign out_side = side[QW];

endmodule
`default_nettype wire

@@ rtl/core/gvq_isqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gvq_isqrt (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [31:0]                sum_sq,
  output      logic                       done,
  output      logic [gvq_pkg::LEN_W-1:0]  root
);
  import gvq_pkg::*;

  localparam int CW = $clog2(ROOT_STEPS);

  logic [2*ROOT_STEPS-1:0] rad_r;
  logic [LEN_W+1:0]        rem_r;
  logic [LEN_W-1:0]        root_r;
  logic [CW-1:0]           cnt_r;
  logic                    busy_r;
  logic                    done_r;
  logic [LEN_W+3:0]        rem_sh;
  logic [LEN_W+3:0]        trial;
  logic [LEN_W+3:0]        diff;
  logic                    ge;

  always_comb begin
    rem_sh = {rem_r, rad_r[2*ROOT_STEPS-1 -: 2]};
    trial  = {2'b00, root_r, 2'b01};
    diff   = rem_sh - trial;
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(ROOT_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // two radicand bits per step, value is sum_sq scaled by 2^30
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= {2'b00, sum_sq, 30'b0};
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[2*ROOT_STEPS-3:0], 2'b00};
      rem_r  <= ge ? diff[LEN_W+1:0] : rem_sh[LEN_W+1:0];
      root_r <= {root_r[LEN_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire
